// ===== src/mc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mc_pkg: Morse codec shared types, constants and table lookups
// The 39-entry symbol table, the job record passed from front to back, and the
// encode / decode lookup functions.
// ----------------------------------------------------------------------------
package mc_pkg;

  localparam int NUM_SYM    = 39;
  localparam int CODE_MAX   = 6;   // longest code in the table
  localparam int CODE_LEN_W = 3;   // holds 0..CODE_MAX
  localparam int JOBQ_DEPTH = 2;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NONE  = 8'h00;
  localparam logic [7:0] CASE_OFS = 8'd32;

  // Symbol, code length, code bits (bit i = element i, 1 = dash)
  localparam logic [7:0] SYM_TAB [NUM_SYM] = '{
    8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A,
    8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54,
    8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A,
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
    8'h2E, 8'h2C, 8'h3F
  };

  localparam logic [CODE_LEN_W-1:0] LEN_TAB [NUM_SYM] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
    3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
    3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
    3'd6, 3'd6, 3'd6
  };

  localparam logic [CODE_MAX-1:0] BITS_TAB [NUM_SYM] = '{
    6'b000010, 6'b000001, 6'b000101, 6'b000001, 6'b000000, // A B C D E
    6'b000100, 6'b000011, 6'b000000, 6'b000000, 6'b001110, // F G H I J
    6'b000101, 6'b000010, 6'b000011, 6'b000001, 6'b000111, // K L M N O
    6'b000110, 6'b001011, 6'b000010, 6'b000000, 6'b000001, // P Q R S T
    6'b000100, 6'b001000, 6'b000110, 6'b001001, 6'b001101, // U V W X Y
    6'b000011,                                             // Z
    6'b011111, 6'b011110, 6'b011100, 6'b011000, 6'b010000, // 0 1 2 3 4
    6'b000000, 6'b000001, 6'b000011, 6'b000111, 6'b001111, // 5 6 7 8 9
    6'b101010, 6'b110011, 6'b001100                        // . , ?
  };

  typedef struct packed {
    logic                  hit;
    logic [CODE_LEN_W-1:0] len;
    logic [CODE_MAX-1:0]   bits;
  } enc_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] sym;
  } dec_t;

  // One unit of back-end work: n_elem code elements, then fin_char (last)
  typedef struct packed {
    logic [CODE_LEN_W-1:0] n_elem;
    logic [CODE_MAX-1:0]   bits;
    logic [7:0]            fin_char;
    logic                  bad;
  } job_t;

  function automatic enc_t enc_lookup(input logic [7:0] ch);
    enc_t r;
    r = '0;
    for (int i = 0; i < NUM_SYM; i++) begin
      if (SYM_TAB[i] == ch) begin
        r.hit  = 1'b1;
        r.len  = LEN_TAB[i];
        r.bits = BITS_TAB[i];
      end
    end
    return r;
  endfunction

  function automatic dec_t dec_lookup(input logic [CODE_LEN_W-1:0] len,
                                      input logic [CODE_MAX-1:0]   bits);
    dec_t r;
    r = '0;
    for (int i = 0; i < NUM_SYM; i++) begin
      if (LEN_TAB[i] == len && BITS_TAB[i] == bits) begin
        r.hit = 1'b1;
        r.sym = SYM_TAB[i];
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/mc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mc_front: input classifier
// Holds the direction register and the decode path. Turns each accepted beat
// into at most one job for the back end.
// ----------------------------------------------------------------------------
module mc_front #(
  parameter int MAX_CODE_LEN = 6
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              cfg_we,
  input  wire              cfg_wdata,
  input  wire              in_acc,
  input  wire [7:0]        in_char,
  output logic             job_push,
  output mc_pkg::job_t     job
);

  localparam int LW = $clog2(MAX_CODE_LEN + 1);
  localparam int IW = $clog2(MAX_CODE_LEN);

  logic                    dir_r, dir_nxt;
  logic [MAX_CODE_LEN-1:0] path_bits_r, path_bits_nxt;
  logic [LW-1:0]           path_len_r, path_len_nxt;
  logic                    path_ovf_r, path_ovf_nxt;

  logic [7:0]   up_char;
  logic         len_ok;
  mc_pkg::enc_t enc;
  mc_pkg::dec_t dec;

  // Fold to upper case, then look up both ways
  always_comb begin
    up_char = (in_char inside {["a":"z"]}) ? in_char - mc_pkg::CASE_OFS : in_char;
    enc     = mc_pkg::enc_lookup(up_char);
    len_ok  = path_len_r <= LW'(mc_pkg::CODE_MAX);
    dec     = mc_pkg::dec_lookup(mc_pkg::CODE_LEN_W'(path_len_r),
                                 mc_pkg::CODE_MAX'(path_bits_r));
  end

  // Classify the beat and update the path
  always_comb begin
    dir_nxt       = dir_r;
    path_bits_nxt = path_bits_r;
    path_len_nxt  = path_len_r;
    path_ovf_nxt  = path_ovf_r;
    job_push      = 1'b0;
    job           = '0;
    job.fin_char  = mc_pkg::CH_SPACE;

    if (cfg_we) begin
      dir_nxt = cfg_wdata;
    end

    if (in_acc) begin
      if (!dir_r) begin
        // encode: space alone, or code then space
        if (up_char == mc_pkg::CH_SPACE) begin
          job_push = 1'b1;
        end else if (enc.hit) begin
          job_push   = 1'b1;
          job.n_elem = enc.len;
          job.bits   = enc.bits;
        end
      end else if (in_char == mc_pkg::CH_DOT || in_char == mc_pkg::CH_DASH) begin
        // decode: extend the path, or flag overflow
        if (path_len_r < LW'(MAX_CODE_LEN)) begin
          if (in_char == mc_pkg::CH_DASH) begin
            path_bits_nxt[path_len_r[IW-1:0]] = 1'b1;
          end
          path_len_nxt = path_len_r + LW'(1);
        end else begin
          path_ovf_nxt = 1'b1;
        end
      end else if (path_len_r != '0 || path_ovf_r) begin
        // separator ends a non-empty letter
        job_push = 1'b1;
        if (path_ovf_r || !len_ok || !dec.hit) begin
          job.fin_char = mc_pkg::CH_NONE;
          job.bad      = 1'b1;
        end else begin
          job.fin_char = dec.sym;
        end
        path_bits_nxt = '0;
        path_len_nxt  = '0;
        path_ovf_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r       <= 1'b0;
      path_bits_r <= '0;
      path_len_r  <= '0;
      path_ovf_r  <= 1'b0;
    end else begin
      dir_r       <= dir_nxt;
      path_bits_r <= path_bits_nxt;
      path_len_r  <= path_len_nxt;
      path_ovf_r  <= path_ovf_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/mc_jobq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mc_jobq: job queue
// Short FIFO between the classifier and the result generator.
// ----------------------------------------------------------------------------
module mc_jobq (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          wr_en,
  input  mc_pkg::job_t wr_data,
  output logic         full,
  input  wire          rd_en,
  output mc_pkg::job_t rd_data,
  output logic         rd_valid
);

  localparam int DEPTH = mc_pkg::JOBQ_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  mc_pkg::job_t     slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full     = cnt_r == CW'(DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = slot_r[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Payload slots
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// ===== src/mc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mc_back: result generator
// Walks the head job one result per cycle, while the output register is empty
// or popped: code elements first, then the closing character flagged last.
// ----------------------------------------------------------------------------
module mc_back (
  input  wire          clk,
  input  wire          rst_n,
  input  mc_pkg::job_t job,
  input  wire          job_valid,
  output logic         job_pop,
  output logic         empty,
  input  wire          pop,
  output logic [7:0]   out_char,
  output logic         out_last,
  output logic         out_bad_code
);

  logic                          out_valid_r, out_valid_nxt;
  logic [7:0]                    out_char_r, out_char_nxt;
  logic                          out_last_r, out_last_nxt;
  logic                          out_bad_r, out_bad_nxt;
  logic [mc_pkg::CODE_LEN_W-1:0] idx_r, idx_nxt;
  logic [mc_pkg::CODE_MAX-1:0]   elem_sh;
  logic                          adv;

  assign empty        = !out_valid_r;
  assign out_char     = out_char_r;
  assign out_last     = out_last_r;
  assign out_bad_code = out_bad_r;

  // Output register frees up when empty or taken this cycle
  assign adv     = !out_valid_r || pop;
  assign elem_sh = job.bits >> idx_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_bad_nxt   = out_bad_r;
    idx_nxt       = idx_r;
    job_pop       = 1'b0;
    if (adv) begin
      out_valid_nxt = job_valid;
      if (job_valid) begin
        if (idx_r < job.n_elem) begin
          out_char_nxt = elem_sh[0] ? mc_pkg::CH_DASH : mc_pkg::CH_DOT;
          out_last_nxt = 1'b0;
          out_bad_nxt  = 1'b0;
          idx_nxt      = idx_r + mc_pkg::CODE_LEN_W'(1);
        end else begin
          out_char_nxt = job.fin_char;
          out_last_nxt = 1'b1;
          out_bad_nxt  = job.bad;
          idx_nxt      = '0;
          job_pop      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_bad_r  <= out_bad_nxt;
  end

endmodule
`default_nettype wire

// ===== src/morse_codec.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// morse_codec: Morse code encoder / decoder
// Channels: text or dot/dash bytes go in on a push/full queue port; result
// beats come out on an empty/pop queue port (out_char, out_last marks the final
// beat of one input, out_bad_code flags an unknown or over-long letter).
// cfg_we/cfg_wdata set direction (0 encode, 1 decode) while the block is idle.
// Path: an accepted beat is written into the job queue, then registered in the
// output register; empty goes low once that register holds its first result.
// Throughput: the input side takes one beat per cycle until the two-entry job
// queue fills. The output register emits one result per cycle while popped, so
// an encoded character of k elements gives k+1 results (up to 7); decoded
// characters and spaces give one result each. Beats that produce no result
// (dots and dashes in decode, unknown characters in encode) take no queue entry.
// Stall: when pop stays low the result holds and the job queue fills; full
// then rises and input stalls. Reset clears queue, output, path and
// direction (encode).
// ----------------------------------------------------------------------------
module morse_codec #(
  parameter int MAX_CODE_LEN = 6
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        cfg_we,
  input  wire        cfg_wdata,
  input  wire        push,
  output logic       full,
  input  wire [7:0]  in_char,
  output logic       empty,
  input  wire        pop,
  output logic [7:0] out_char,
  output logic       out_last,
  output logic       out_bad_code
);

  logic         in_acc;
  logic         job_push;
  mc_pkg::job_t job_in;
  mc_pkg::job_t job_head;
  logic         job_valid;
  logic         job_pop;

  assign in_acc = push && !full;

  mc_front #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_acc    (in_acc),
    .in_char   (in_char),
    .job_push  (job_push),
    .job       (job_in)
  );

  mc_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (job_push),
    .wr_data  (job_in),
    .full     (full),
    .rd_en    (job_pop),
    .rd_data  (job_head),
    .rd_valid (job_valid)
  );

  mc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .job          (job_head),
    .job_valid    (job_valid),
    .job_pop      (job_pop),
    .empty        (empty),
    .pop          (pop),
    .out_char     (out_char),
    .out_last     (out_last),
    .out_bad_code (out_bad_code)
  );

endmodule
`default_nettype wire

// ===== src/mc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mc_checker: port-level checks for morse_codec
// Watches the result port over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module mc_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       empty,
  input wire       pop,
  input wire [7:0] out_char,
  input wire       out_last,
  input wire       out_bad_code
);

  // Nothing waits on the result side right after reset
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("result present right after reset");

  // A stalled beat holds
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_char) && $stable(out_last)
                          && $stable(out_bad_code)))
    else $error("stalled result changed");

  // An error result is always the closing beat with a null character
  a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_bad_code) |-> (out_last && out_char == mc_pkg::CH_NONE))
    else $error("bad_code beat not final or not null");

  // Only code elements precede the closing beat
  a_mid_is_element: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_last) |-> (out_char == mc_pkg::CH_DOT
                               || out_char == mc_pkg::CH_DASH))
    else $error("non-final beat is not a dot or dash");

endmodule

bind morse_codec mc_checker u_mc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .empty        (empty),
  .pop          (pop),
  .out_char     (out_char),
  .out_last     (out_last),
  .out_bad_code (out_bad_code)
);
`default_nettype wire

// ===== tb/morse_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_checker: result predictor and scoreboard for the Morse codec
// Watches the config port and both queue ports. Each accepted input beat is
// translated here into the result beats it should cause, which wait in order
// until the receiver pops them; every popped beat is compared field by field.
// ----------------------------------------------------------------------------
package morse_tb_pkg;

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } codec_dir_t;

  // Dot/dash spelling of one upper-case table character, empty if not in table
  function automatic string morse_code(input logic [7:0] sym);
    case (sym)
      "A": return ".-";     "B": return "-...";   "C": return "-.-.";
      "D": return "-..";    "E": return ".";      "F": return "..-.";
      "G": return "--.";    "H": return "....";   "I": return "..";
      "J": return ".---";   "K": return "-.-";    "L": return ".-..";
      "M": return "--";     "N": return "-.";     "O": return "---";
      "P": return ".--.";   "Q": return "--.-";   "R": return ".-.";
      "S": return "...";    "T": return "-";      "U": return "..-";
      "V": return "...-";   "W": return ".--";    "X": return "-..-";
      "Y": return "-.--";   "Z": return "--..";
      "0": return "-----";  "1": return ".----";  "2": return "..---";
      "3": return "...--";  "4": return "....-";  "5": return ".....";
      "6": return "-....";  "7": return "--...";  "8": return "---..";
      "9": return "----.";
      ".": return ".-.-.-"; ",": return "--..--"; "?": return "..--..";
      default: return "";
    endcase
  endfunction

endpackage

module morse_checker (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        cfg_we,
  input  wire        cfg_wdata,
  input  wire        push,
  input  wire        full,
  input  wire [7:0]  in_char,
  input  wire        empty,
  input  wire        pop,
  input  wire [7:0]  out_char,
  input  wire        out_last,
  input  wire        out_bad_code,
  output int         fail_cnt,
  output int         pend_cnt
);

  localparam int MAX_ELEMS  = 6;
  localparam int SHOW_FAILS = 10;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    logic       bad;
  } morse_beat_t;

  morse_beat_t due_beats[$];

  // Mirror of the codec state
  morse_tb_pkg::codec_dir_t dir;
  logic [5:0]  path_bits;
  logic [2:0]  path_len;
  logic        path_ovf;

  // {hit, symbol} for a stored dot/dash path
  function automatic logic [8:0] lookup_path(input logic [2:0] len,
                                             input logic [5:0] bits);
    string      code;
    logic [5:0] b;
    lookup_path = '0;
    for (int s = 0; s < 256; s++) begin
      code = morse_tb_pkg::morse_code(8'(s));
      b = '0;
      for (int j = 0; j < code.len(); j++)
        if (code[j] == mc_pkg::CH_DASH) b[j] = 1'b1;
      if (code.len() != 0 && code.len() == int'(len) && b == bits)
        lookup_path = {1'b1, 8'(s)};
    end
  endfunction

  task automatic add_beat(input logic [7:0] ch, input logic fin, input logic bad);
    due_beats.push_back('{ch: ch, fin: fin, bad: bad});
  endtask

  // Work out the result beats of one accepted input beat
  task automatic translate_char(input logic [7:0] c_in);
    logic [7:0] c;
    string      code;
    logic [8:0] hit_sym;
    c = c_in;
    if (dir == morse_tb_pkg::DIR_ENCODE) begin
      if (c >= "a" && c <= "z") c = c - 8'd32;
      if (c == mc_pkg::CH_SPACE) begin
        add_beat(mc_pkg::CH_SPACE, 1'b1, 1'b0);
      end else begin
        code = morse_tb_pkg::morse_code(c);
        if (code.len() != 0) begin
          for (int i = 0; i < code.len(); i++) add_beat(code[i], 1'b0, 1'b0);
          add_beat(mc_pkg::CH_SPACE, 1'b1, 1'b0);
        end
      end
    end else if (c == mc_pkg::CH_DOT || c == mc_pkg::CH_DASH) begin
      // extend the path, or note that it ran past the longest code
      if (int'(path_len) < MAX_ELEMS) begin
        if (c == mc_pkg::CH_DASH) path_bits[path_len] = 1'b1;
        path_len = path_len + 3'd1;
      end else begin
        path_ovf = 1'b1;
      end
    end else if (path_len != 0 || path_ovf) begin
      // separator ends the letter; empty letters give nothing
      if (path_ovf) begin
        add_beat(mc_pkg::CH_NONE, 1'b1, 1'b1);
      end else begin
        hit_sym = lookup_path(path_len, path_bits);
        if (hit_sym[8]) add_beat(hit_sym[7:0], 1'b1, 1'b0);
        else            add_beat(mc_pkg::CH_NONE, 1'b1, 1'b1);
      end
      path_bits = '0;
      path_len  = '0;
      path_ovf  = 1'b0;
    end
  endtask

  // Compare one popped beat with the oldest expectation
  task automatic check_beat();
    morse_beat_t want;
    if (due_beats.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= SHOW_FAILS)
        $display("%0t: unexpected beat char=%h last=%b bad=%b", $realtime,
                 out_char, out_last, out_bad_code);
    end else begin
      want = due_beats.pop_front();
      if (out_char !== want.ch || out_last !== want.fin
          || out_bad_code !== want.bad) begin
        fail_cnt++;
        if (fail_cnt <= SHOW_FAILS)
          $display("%0t: beat mismatch: expected %h/%b/%b, got %h/%b/%b",
                   $realtime, want.ch, want.fin, want.bad,
                   out_char, out_last, out_bad_code);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      dir       = morse_tb_pkg::DIR_ENCODE;
      path_bits = '0;
      path_len  = '0;
      path_ovf  = 1'b0;
      due_beats.delete();
    end else begin
      if (pop && !empty) check_beat();
      if (cfg_we) dir = morse_tb_pkg::codec_dir_t'(cfg_wdata);
      if (push && !full) translate_char(in_char);
    end
    pend_cnt = due_beats.size();
  end

endmodule

// ===== tb/tb_morse_codec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_morse_codec: stimulus and verdict for the Morse codec
// Directed encode and decode letters first (table extremes, empty, unknown and
// over-long letters), then random phases that alternate direction with mostly
// well-formed letters plus noise, random idling on both sides and one long
// receiver hold-off. Checking is done by morse_checker.
// ----------------------------------------------------------------------------
module tb_morse_codec;

  localparam int    CLK_HALF   = 10;
  localparam int    ITEMS      = 410;
  localparam int    CALM_ITEMS = 60;       // final stretch without idling
  localparam int    HOLD_LEN   = 400;
  localparam int    SETTLE     = 8;
  localparam int    LIMIT      = 400000;
  localparam string SYM_LIST   = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.,?";

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       cfg_we    = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       push      = 1'b0;
  logic [7:0] in_char   = '0;
  logic       pop       = 1'b0;
  wire        full;
  wire        empty;
  wire  [7:0] out_char;
  wire        out_last;
  wire        out_bad_code;

  int fail_cnt;
  int pend_cnt;
  int cycles = 0;
  int sent   = 0;
  bit tx_idle    = 1'b1;
  bit rx_idle    = 1'b1;
  bit hold_armed = 1'b0;

  always #(CLK_HALF) clk = ~clk;

  morse_codec dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .push         (push),
    .full         (full),
    .in_char      (in_char),
    .empty        (empty),
    .pop          (pop),
    .out_char     (out_char),
    .out_last     (out_last),
    .out_bad_code (out_bad_code)
  );

  morse_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .push         (push),
    .full         (full),
    .in_char      (in_char),
    .empty        (empty),
    .pop          (pop),
    .out_char     (out_char),
    .out_last     (out_last),
    .out_bad_code (out_bad_code),
    .fail_cnt     (fail_cnt),
    .pend_cnt     (pend_cnt)
  );

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb_morse_codec NOT OK");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off once armed
  initial begin : rx_side
    bit hold_done;
    hold_done = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else if (rx_idle && $urandom_range(0, 6) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one input beat until accepted; push stays high afterwards
  task automatic send_beat(input logic [7:0] c);
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    push    <= 1'b1;
    in_char <= c;
    do @(posedge clk); while (full);
    sent++;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (pend_cnt != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_direction(input morse_tb_pkg::codec_dir_t d);
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [7:0] pick_separator();
    logic [7:0] c;
    if ($urandom_range(0, 3) != 0) return mc_pkg::CH_SPACE;
    do c = 8'($urandom_range(0, 255)); while (c == mc_pkg::CH_DOT || c == mc_pkg::CH_DASH);
    return c;
  endfunction

  function automatic logic [7:0] pick_element();
    return $urandom_range(0, 1) ? mc_pkg::CH_DASH : mc_pkg::CH_DOT;
  endfunction

  task automatic send_text_char();
    int r;
    r = $urandom_range(0, 9);
    if (r <= 4)      send_beat(SYM_LIST[$urandom_range(0, SYM_LIST.len() - 1)]);
    else if (r <= 6) send_beat(8'($urandom_range("a", "z")));
    else if (r == 7) send_beat(mc_pkg::CH_SPACE);
    else             send_beat(8'($urandom_range(0, 255)));
  endtask

  // One decode group: mostly a real letter, else noise or broken letters
  task automatic send_decode_group();
    int    r;
    int    n;
    string code;
    r = $urandom_range(0, 9);
    if (r <= 6) begin
      code = morse_tb_pkg::morse_code(SYM_LIST[$urandom_range(0, SYM_LIST.len() - 1)]);
      for (int i = 0; i < code.len(); i++) send_beat(code[i]);
      send_beat(pick_separator());
    end else if (r == 8) begin
      send_beat(8'($urandom_range(0, 255)));
    end else begin
      n = (r == 7) ? $urandom_range(0, 9) : $urandom_range(6, 8);
      repeat (n) send_beat(pick_element());
      send_beat(pick_separator());
    end
  endtask

  initial begin : stim
    morse_tb_pkg::codec_dir_t dir;
    int         phase;
    int         goal;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed encode at reset direction
    send_beat("a");
    send_beat("Z");
    send_beat("0");
    send_beat("?");
    send_beat(8'hFF);
    send_beat(mc_pkg::CH_SPACE);
    push <= 1'b0;
    wait_drained();

    // Directed decode: letter, empty letter, six-element letter, too-long letter
    set_direction(morse_tb_pkg::DIR_DECODE);
    send_beat(mc_pkg::CH_DOT);
    send_beat(mc_pkg::CH_DASH);
    send_beat(mc_pkg::CH_SPACE);
    send_beat(8'h00);
    send_beat(mc_pkg::CH_DASH);
    send_beat(mc_pkg::CH_DASH);
    send_beat(mc_pkg::CH_DOT);
    send_beat(mc_pkg::CH_DOT);
    send_beat(mc_pkg::CH_DASH);
    send_beat(mc_pkg::CH_DASH);
    send_beat(8'hFF);
    repeat (7) send_beat(mc_pkg::CH_DASH);
    send_beat("?");
    // partial path left across the next direction change
    send_beat(mc_pkg::CH_DOT);
    send_beat(mc_pkg::CH_DOT);
    push <= 1'b0;

    // Random phases, alternating direction
    phase = 0;
    while (sent < ITEMS) begin
      wait_drained();
      dir = morse_tb_pkg::codec_dir_t'(phase % 2);
      set_direction(dir);
      if (phase == 0) hold_armed = 1'b1;
      goal = sent + $urandom_range(30, 70);
      while (sent < goal && sent < ITEMS) begin
        // no idling on either side in the final stretch
        if (sent >= ITEMS - CALM_ITEMS) begin
          tx_idle = 1'b0;
          rx_idle = 1'b0;
        end
        if (dir == morse_tb_pkg::DIR_ENCODE) send_text_char();
        else                                 send_decode_group();
      end
      push <= 1'b0;
      phase++;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_cnt == 0 && pend_cnt == 0)
      $display("tb_morse_codec OK");
    else
      $display("tb_morse_codec NOT OK");
    $finish;
  end

endmodule

// ===== morse_codec.f =====
src/mc_pkg.sv
src/mc_front.sv
src/mc_jobq.sv
src/mc_back.sv
src/morse_codec.sv
src/mc_checker.sv
tb/morse_checker.sv
tb/tb_morse_codec.sv
